FILE: rtl/mcu_pkg.sv
// ============================================================================
// Motor command update package
// Shared constants, command codes and lane/merge control types.
// ============================================================================
package mcu_pkg;

	localparam int NUM_MOTORS = 4;
	localparam int MOTOR_W    = 2;
	localparam int POWER_W    = 8;
	localparam int SCALE_W    = 7;

	// The scaled dividend is |power| * full_scale <= 128 * 127, which fits 14 bits.
	localparam int PROD_W     = 14;
	// The divider retires two quotient bits per cycle.
	localparam int DIV_CYCLES = PROD_W / 2;
	localparam int CNT_W      = $clog2(DIV_CYCLES);

	localparam logic [SCALE_W-1:0] FULL_SCALE_RST = 7'd100;

	localparam logic LETTER_F = 1'b1;
	localparam logic LETTER_R = 1'b0;

	typedef enum logic [1:0] {
		CMD_SET_ALL = 2'd0,
		CMD_SET_ONE = 2'd1,
		CMD_STOP    = 2'd2
	} cmd_t;

	typedef logic signed [POWER_W-1:0] power_t;

	typedef struct packed {
		logic                 start;
		logic                 scale;
		power_t               power;
		logic [SCALE_W-1:0]   full_scale;
		logic [POWER_W-1:0]   max_mag;
	} lane_cmd_t;

	typedef struct packed {
		logic               load;
		logic [1:0]         cmd;
		logic [MOTOR_W-1:0] sel;
	} merge_ctl_t;

	// Magnitude of a signed power; the most negative value gives 128.
	function automatic logic [POWER_W-1:0] mag8(power_t p);
		return p[POWER_W-1] ? POWER_W'(-p) : POWER_W'(p);
	endfunction

endpackage

FILE: rtl/mcu_req_if.sv
// ============================================================================
// Motor command request channel
// Valid/ready channel carrying one motor command.
// ============================================================================
interface mcu_req_if;
	logic              valid;
	logic              ready;
	logic [1:0]        cmd;
	logic signed [7:0] power_a;
	logic signed [7:0] power_b;
	logic signed [7:0] power_c;
	logic signed [7:0] power_d;
	logic [1:0]        motor_select;
	logic              maximize;

	modport source (output valid, cmd, power_a, power_b, power_c, power_d, motor_select,
		maximize, input ready);
	modport sink (input valid, cmd, power_a, power_b, power_c, power_d, motor_select,
		maximize, output ready);
endinterface

FILE: rtl/mcu_upd_if.sv
// ============================================================================
// Motor update channel
// Valid/ready channel carrying one motor power update.
// ============================================================================
interface mcu_upd_if;
	logic       valid;
	logic       ready;
	logic [1:0] motor_index;
	logic       letter_f;
	logic [7:0] magnitude;
	logic       last_of_run;

	modport source (output valid, motor_index, letter_f, magnitude, last_of_run,
		input ready);
	modport sink (input valid, motor_index, letter_f, magnitude, last_of_run,
		output ready);
endinterface

FILE: rtl/mcu_cfg_if.sv
// ============================================================================
// Full-scale configuration channel
// Valid/ready write channel for the full-scale register.
// ============================================================================
interface mcu_cfg_if;
	logic       valid;
	logic       ready;
	logic [6:0] full_scale;

	modport source (output valid, full_scale, input ready);
	modport sink (input valid, full_scale, output ready);
endinterface

FILE: rtl/mcu_lane.sv
// ============================================================================
// Motor power lane
// Scales one power by full_scale / max_mag with a radix-4 restoring divider,
// or passes the power through unchanged.
// ============================================================================
module mcu_lane import mcu_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  lane_cmd_t lcmd,
	output logic      done,
	output power_t    result
);

	typedef enum logic {L_IDLE, L_DIV} lstate_t;

	lstate_t            state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [PROD_W-1:0]  dq_q;
	logic [POWER_W-1:0] rem_q;
	logic [POWER_W-1:0] m_q;
	logic               neg_q;
	logic               done_q;
	power_t             result_q;

	logic [PROD_W-1:0]  prod;
	logic [POWER_W:0]   ra, rb;
	logic               ga, gb;
	logic [POWER_W-1:0] ra_n, rb_n;
	logic [PROD_W-1:0]  dq_n;
	logic [POWER_W-1:0] q8;
	power_t             res_n;

	always_comb begin
		prod = PROD_W'(PROD_W'(mag8(lcmd.power)) * PROD_W'(lcmd.full_scale));
		// Two restoring steps per cycle; quotient bits shift in as dividend bits leave.
		ra   = {rem_q, dq_q[PROD_W-1]};
		ga   = ra >= {1'b0, m_q};
		ra_n = ga ? POWER_W'(ra - {1'b0, m_q}) : ra[POWER_W-1:0];
		rb   = {ra_n, dq_q[PROD_W-2]};
		gb   = rb >= {1'b0, m_q};
		rb_n = gb ? POWER_W'(rb - {1'b0, m_q}) : rb[POWER_W-1:0];
		dq_n = {dq_q[PROD_W-3:0], ga, gb};
		// The quotient never exceeds full_scale, so its low byte is the whole value.
		q8   = dq_n[POWER_W-1:0];
		res_n = neg_q ? power_t'(POWER_W'(0) - q8) : power_t'(q8);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= L_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				L_IDLE: begin
					if (lcmd.start) begin
						if (lcmd.scale) begin
							state_q <= L_DIV;
							cnt_q   <= '0;
							dq_q    <= prod;
							rem_q   <= '0;
							m_q     <= lcmd.max_mag;
							neg_q   <= lcmd.power[POWER_W-1];
						end else begin
							result_q <= lcmd.power;
							done_q   <= 1'b1;
						end
					end
				end
				L_DIV: begin
					dq_q  <= dq_n;
					rem_q <= rb_n;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(DIV_CYCLES - 1)) begin
						state_q  <= L_IDLE;
						result_q <= res_n;
						done_q   <= 1'b1;
					end
				end
				default: state_q <= L_IDLE;
			endcase
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

FILE: rtl/mcu_merge.sv
// ============================================================================
// Motor update merge stage
// Compares lane results with the stored powers and emits one update per change
// (for every motor on a stop) through a registered output.
// ============================================================================
module mcu_merge import mcu_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  merge_ctl_t              mctl,
	input  power_t [NUM_MOTORS-1:0] res,
	output logic                    busy,
	mcu_upd_if.source               upd
);

	power_t [NUM_MOTORS-1:0] stored_q;
	power_t [NUM_MOTORS-1:0] new_q;
	logic [NUM_MOTORS-1:0]   pend_q;
	logic                    stop_q;

	logic                    out_valid_q;
	logic [MOTOR_W-1:0]      out_idx_q;
	logic                    out_letter_q;
	logic [POWER_W-1:0]      out_mag_q;
	logic                    out_last_q;

	logic [NUM_MOTORS-1:0]   chg;
	power_t [NUM_MOTORS-1:0] nv;
	logic [MOTOR_W-1:0]      idx;
	logic [NUM_MOTORS-1:0]   rest;
	logic                    emit;

	always_comb begin
		for (int i = 0; i < NUM_MOTORS; i++) begin
			unique case (mctl.cmd)
				CMD_SET_ALL: begin
					nv[i]  = res[i];
					chg[i] = res[i] != stored_q[i];
				end
				CMD_SET_ONE: begin
					// Lane 0 carries the single power.
					nv[i]  = res[0];
					chg[i] = (MOTOR_W'(i) == mctl.sel) && (res[0] != stored_q[i]);
				end
				CMD_STOP: begin
					nv[i]  = '0;
					chg[i] = 1'b1;
				end
				default: begin
					nv[i]  = stored_q[i];
					chg[i] = 1'b0;
				end
			endcase
		end

		idx = '0;
		for (int i = NUM_MOTORS - 1; i >= 0; i--) begin
			if (pend_q[i]) idx = MOTOR_W'(i);
		end
		rest = pend_q;
		rest[idx] = 1'b0;
		emit = (pend_q != '0) && (!out_valid_q || upd.ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stored_q    <= '0;
			pend_q      <= '0;
			stop_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (mctl.load) begin
				for (int i = 0; i < NUM_MOTORS; i++) begin
					if (chg[i]) stored_q[i] <= nv[i];
				end
				new_q  <= nv;
				pend_q <= chg;
				stop_q <= mctl.cmd == CMD_STOP;
			end else if (emit) begin
				pend_q <= rest;
			end

			if (emit) begin
				out_valid_q  <= 1'b1;
				out_idx_q    <= idx;
				out_letter_q <= (stop_q || new_q[idx][POWER_W-1]) ? LETTER_F : LETTER_R;
				out_mag_q    <= mag8(new_q[idx]);
				out_last_q   <= rest == '0;
			end else if (upd.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign busy            = pend_q != '0;
	assign upd.valid       = out_valid_q;
	assign upd.motor_index = out_idx_q;
	assign upd.letter_f    = out_letter_q;
	assign upd.magnitude   = out_mag_q;
	assign upd.last_of_run = out_last_q;

endmodule

FILE: rtl/motor_command_update_top.sv
// ============================================================================
// Motor command update block
// Keeps the last power of four motors and emits an update for every change.
// ============================================================================
// The block takes one command request at a time. Set-all hands the four
// powers to four identical lanes; with maximize set and a nonzero largest
// magnitude, every lane divides |power| * full_scale by that magnitude in a
// radix-4 divider and restores the sign, otherwise the lanes pass their
// power through. A merge stage then compares the lane results with the
// stored powers, stores the new ones and emits one update per changed motor,
// lowest motor first, one per cycle while the sink takes them. The first
// update passes through the lane result register and the merge stage's
// pending flags to its output register. A new request is taken once the
// last update of the previous one sits in the output register. Stop always
// emits four zero updates flagged with the F letter. The full-scale
// register may be written at any time the block is idle.
// ============================================================================
module motor_command_update_top import mcu_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	mcu_req_if.sink   req,
	mcu_cfg_if.sink   cfg,
	mcu_upd_if.source upd
);

	// Full-scale configuration register, always ready for a write.
	logic [SCALE_W-1:0] full_scale_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_scale_q <= FULL_SCALE_RST;
		end else if (cfg.valid) begin
			full_scale_q <= cfg.full_scale;
		end
	end

	// Request acceptance. The block holds one request from acceptance until
	// the lanes finish, and the merge stage must have drained its updates.
	logic                    busy_q;
	logic [1:0]              cmd_q;
	logic [MOTOR_W-1:0]      sel_q;
	logic                    mrg_busy;
	logic                    accept;
	logic [NUM_MOTORS-1:0]   lane_done;
	power_t [NUM_MOTORS-1:0] lane_res;

	assign req.ready = !busy_q && !mrg_busy;
	assign accept    = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
				cmd_q  <= req.cmd;
				sel_q  <= req.motor_select;
			end else if (lane_done[0]) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Largest magnitude of the four powers, found while the request is taken.
	power_t [NUM_MOTORS-1:0] pw;
	logic [POWER_W-1:0]      mag_ab, mag_cd, max_mag;
	logic                    scale;

	always_comb begin
		pw[0]   = req.power_a;
		pw[1]   = req.power_b;
		pw[2]   = req.power_c;
		pw[3]   = req.power_d;
		mag_ab  = (mag8(pw[0]) > mag8(pw[1])) ? mag8(pw[0]) : mag8(pw[1]);
		mag_cd  = (mag8(pw[2]) > mag8(pw[3])) ? mag8(pw[2]) : mag8(pw[3]);
		max_mag = (mag_ab > mag_cd) ? mag_ab : mag_cd;
		// With all powers zero there is nothing to scale, and they stay zero.
		scale   = req.maximize && (max_mag != '0) && (req.cmd == CMD_SET_ALL);
	end

	// One lane per motor; all lanes start together and finish together.
	for (genvar g = 0; g < NUM_MOTORS; g++) begin : g_lane
		lane_cmd_t lcmd;

		always_comb begin
			lcmd.start      = accept;
			lcmd.scale      = scale;
			lcmd.power      = pw[g];
			lcmd.full_scale = full_scale_q;
			lcmd.max_mag    = max_mag;
		end

		mcu_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.lcmd   (lcmd),
			.done   (lane_done[g]),
			.result (lane_res[g])
		);
	end

	// Merge stage: change detection, stored powers and the update output.
	merge_ctl_t mctl;

	always_comb begin
		mctl.load = lane_done[0];
		mctl.cmd  = cmd_q;
		mctl.sel  = sel_q;
	end

	mcu_merge u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.mctl   (mctl),
		.res    (lane_res),
		.busy   (mrg_busy),
		.upd    (upd)
	);

	// The lanes run in lockstep, so they report completion in the same cycle.
	a_lane_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		(lane_done == '0) || (lane_done == '1))
		else $error("lanes finished in different cycles");

	// A lane only finishes while a request is in flight.
	a_done_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		lane_done[0] |-> busy_q)
		else $error("lane finished with no request in flight");

	// The block only becomes busy by accepting a request.
	a_busy_from_accept: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy_q) |-> $past(req.valid && req.ready))
		else $error("busy without an accepted request");

endmodule
